// ===== sv/a8pfp_pkg.sv =====
// Shared types and constants for the alpha8 pixel format packer.
`timescale 1ns / 1ps
package a8pfp_pkg;

  typedef enum logic [2:0] {
    FMT_ARGB     = 3'd0,
    FMT_AIRGB    = 3'd1,
    FMT_ARGB4444 = 3'd2,
    FMT_ARGB2554 = 3'd3,
    FMT_ARGB1555 = 3'd4,
    FMT_A8       = 3'd5,
    FMT_A4       = 3'd6,
    FMT_A1       = 3'd7
  } fmt_e;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Register index within the APB map
  localparam logic REG_FORMAT_MODE = 1'b0;

  localparam logic [23:0] WHITE24    = 24'hFF_FFFF;
  localparam logic [15:0] WHITE_4444 = 16'h0FFF;
  localparam logic [15:0] WHITE_2554 = 16'h3FFF;
  localparam logic [15:0] WHITE_1555 = 16'h7FFF;
  localparam logic [7:0]  NIBBLE_HI  = 8'hF0;
  localparam logic [7:0]  BIT_TOP    = 8'h80;

  localparam logic [2:0] BYTES_4 = 3'd4;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_1 = 3'd1;

  localparam logic [2:0] A1_LAST_BIT = 3'd7;

  typedef struct packed {
    fmt_e mode;
    logic clear;
  } cfg_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  byte_count;
    logic        row_done;
  } result_t;

endpackage

// ===== sv/a8pfp_cfg_regs.sv =====
// APB register block holding the surface format selection.
`timescale 1ns / 1ps
module a8pfp_cfg_regs
  import a8pfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  fmt_e mode_q, mode_d;
  logic hit;
  logic wr_en;

  assign hit    = (paddr[2] == REG_FORMAT_MODE) && (paddr[1:0] == 2'b00);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = fmt_e'(pwdata[2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FMT_ARGB;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = hit ? {29'd0, mode_q} : '0;

  assign cfg_o.mode  = mode_q;
  assign cfg_o.clear = wr_en;

endmodule

// ===== sv/a8pfp_in_stage.sv =====
// Input register stage for the alpha pixel beat.
`timescale 1ns / 1ps
module a8pfp_in_stage
  import a8pfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] alpha_i,
  input  logic       row_end_i,
  input  logic       consume_i,
  output logic       in_stall_o,
  output logic       valid_o,
  output logic [7:0] alpha_o,
  output logic       row_end_o
);

  logic       valid_q;
  logic [7:0] alpha_q;
  logic       row_end_q;
  logic       load;

  // Slot frees up in the same cycle its beat moves on
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load || consume_i) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      alpha_q   <= alpha_i;
      row_end_q <= row_end_i;
    end
  end

  assign valid_o   = valid_q;
  assign alpha_o   = alpha_q;
  assign row_end_o = row_end_q;

endmodule

// ===== sv/a8pfp_convert.sv =====
// Format conversion and A4/A1 packing with its partial-byte state.
`timescale 1ns / 1ps
module a8pfp_convert
  import a8pfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic [7:0] alpha_i,
  input  logic       row_end_i,
  input  logic       fire_i,
  output logic       has_result_o,
  output result_t    result_o
);

  logic [7:0] accum_q, accum_d;
  logic [2:0] count_q, count_d;
  logic [7:0] a1_byte;

  // top alpha bit lands at the next free position, MSB first
  assign a1_byte = accum_q | ((alpha_i & BIT_TOP) >> count_q);

  always_comb begin
    accum_d             = accum_q;
    count_d             = count_q;
    has_result_o        = 1'b1;
    result_o.out_word   = '0;
    result_o.byte_count = BYTES_1;
    result_o.row_done   = row_end_i;
    case (cfg_i.mode)
      FMT_ARGB: begin
        result_o.out_word   = {alpha_i, WHITE24};
        result_o.byte_count = BYTES_4;
      end
      FMT_AIRGB: begin
        result_o.out_word   = {~alpha_i, WHITE24};
        result_o.byte_count = BYTES_4;
      end
      FMT_ARGB4444: begin
        result_o.out_word   = {16'd0, {alpha_i, 8'd0} | WHITE_4444};
        result_o.byte_count = BYTES_2;
      end
      FMT_ARGB2554: begin
        result_o.out_word   = {16'd0, {alpha_i, 8'd0} | WHITE_2554};
        result_o.byte_count = BYTES_2;
      end
      FMT_ARGB1555: begin
        result_o.out_word   = {16'd0, {alpha_i, 8'd0} | WHITE_1555};
        result_o.byte_count = BYTES_2;
      end
      FMT_A8: begin
        result_o.out_word = {24'd0, alpha_i};
      end
      FMT_A4: begin
        if (count_q == 3'd0) begin
          // first nibble: hold it unless the row ends here
          result_o.out_word = {24'd0, alpha_i & NIBBLE_HI};
          result_o.row_done = 1'b1;
          if (!row_end_i) begin
            has_result_o = 1'b0;
            accum_d      = alpha_i & NIBBLE_HI;
            count_d      = 3'd1;
          end
        end else begin
          result_o.out_word = {24'd0, accum_q[7:4], alpha_i[7:4]};
          accum_d           = '0;
          count_d           = '0;
        end
      end
      FMT_A1: begin
        result_o.out_word = {24'd0, a1_byte};
        if ((count_q == A1_LAST_BIT) || row_end_i) begin
          accum_d = '0;
          count_d = '0;
        end else begin
          has_result_o = 1'b0;
          accum_d      = a1_byte;
          count_d      = count_q + 3'd1;
        end
      end
      default: begin
        result_o.out_word = {24'd0, alpha_i};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= '0;
    end else if (cfg_i.clear) begin
      accum_q <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      accum_q <= accum_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/a8pfp_out_stage.sv =====
// Result register driving the output channel.
`timescale 1ns / 1ps
module a8pfp_out_stage
  import a8pfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  result_t     result_i,
  input  logic        out_stall_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  output logic [31:0] out_word_o,
  output logic [2:0]  byte_count_o,
  output logic        row_done_o
);

  logic    valid_q;
  result_t data_q;

  assign can_load_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && push_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_word_o   = data_q.out_word;
  assign byte_count_o = data_q.byte_count;
  assign row_done_o   = data_q.row_done;

endmodule

// ===== sv/alpha8_to_pixel_format_packer_core.sv =====
// Top level of the alpha8 to surface pixel format packer.
//
// Input channel: one 8-bit alpha pixel per beat (alpha_i) with row_end_i on
// the last pixel of a row; in_valid_i / in_stall_o.
// Output channel: out_word_o right aligned, byte_count_o valid bytes,
// row_done_o closing the row; out_valid_o / out_stall_i.
// APB port: register 0 at address 0 selects the format; a write also drops
// any partial A4/A1 byte. Write only while the block is idle.
// Pipeline: an accepted beat passes the input register, then the result
// register, and its result is then on the outputs. Throughput: one beat per
// cycle unless stalled, set by the single conversion stage between the two.
// A4 and A1 produce one result per two or eight pixels, or at row end.
// Reset: format ARGB, pack state empty, both pipeline slots empty.
// Stall: the result register holds; the input slot holds its beat only if
// that beat has a result and the result register cannot take it, so
// beats that yield no result keep flowing.
`timescale 1ns / 1ps
module alpha8_to_pixel_format_packer_core
  import a8pfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       alpha_i,
  input  logic             row_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      out_word_o,
  output logic [2:0]       byte_count_o,
  output logic             row_done_o
);

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_alpha;
  logic       s1_row_end;
  logic       s1_fire;
  logic       has_result;
  logic       out_can_load;
  result_t    result;

  assign s1_fire = s1_valid && (!has_result || out_can_load);

  a8pfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  a8pfp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .alpha_i    (alpha_i),
    .row_end_i  (row_end_i),
    .consume_i  (s1_fire),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .alpha_o    (s1_alpha),
    .row_end_o  (s1_row_end)
  );

  a8pfp_convert u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .alpha_i      (s1_alpha),
    .row_end_i    (s1_row_end),
    .fire_i       (s1_fire),
    .has_result_o (has_result),
    .result_o     (result)
  );

  a8pfp_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s1_fire && has_result),
    .result_i     (result),
    .out_stall_i  (out_stall_i),
    .can_load_o   (out_can_load),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .byte_count_o (byte_count_o),
    .row_done_o   (row_done_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the alpha8 to pixel format packer core.
`timescale 1ns / 1ps
module tb;
  import a8pfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned UNMAPPED_REG   = 1;
  localparam logic [AddrW-1:0] FORMAT_ADDR   = AddrW'(4 * REG_FORMAT_MODE);
  localparam logic [AddrW-1:0] UNMAPPED_ADDR = AddrW'(4 * UNMAPPED_REG);

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [7:0]       alpha     = 8'h00;
  logic             row_end   = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      out_word;
  logic [2:0]       byte_count;
  logic             row_done;

  // predictor state
  fmt_e       fmt_model = FMT_ARGB;
  logic [7:0] acc_byte  = 8'h00;
  logic [2:0] acc_cnt   = 3'd0;

  result_t expected_words[$];
  int      pixels_sent   = 0;
  int      errors        = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_req      = 0;
  int      hold_left     = 0;
  int      quiet_cycles  = 0;

  alpha8_to_pixel_format_packer_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .alpha_i     (alpha),
    .row_end_i   (row_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .byte_count_o(byte_count),
    .row_done_o  (row_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
  endtask

  // Converts one pixel; returns 1 when the pixel completes a result.
  function automatic bit convert_pixel(input logic [7:0] a, input logic last,
                                       output result_t r);
    logic [7:0] b;
    r = '0;
    r.row_done = last;
    r.byte_count = BYTES_1;
    case (fmt_model)
      FMT_ARGB: begin
        r.out_word = {a, WHITE24};
        r.byte_count = BYTES_4;
        return 1'b1;
      end
      FMT_AIRGB: begin
        r.out_word = {~a, WHITE24};
        r.byte_count = BYTES_4;
        return 1'b1;
      end
      FMT_ARGB4444: begin
        r.out_word = {16'h0000, ({a, 8'h00} | WHITE_4444)};
        r.byte_count = BYTES_2;
        return 1'b1;
      end
      FMT_ARGB2554: begin
        r.out_word = {16'h0000, ({a, 8'h00} | WHITE_2554)};
        r.byte_count = BYTES_2;
        return 1'b1;
      end
      FMT_ARGB1555: begin
        r.out_word = {16'h0000, ({a, 8'h00} | WHITE_1555)};
        r.byte_count = BYTES_2;
        return 1'b1;
      end
      FMT_A8: begin
        r.out_word = {24'h0, a};
        return 1'b1;
      end
      FMT_A4: begin
        if (acc_cnt == 3'd0) begin
          if (last) begin
            r.out_word = {24'h0, a & NIBBLE_HI};
            return 1'b1;
          end
          acc_byte = a & NIBBLE_HI;
          acc_cnt = 3'd1;
          return 1'b0;
        end
        b = (acc_byte & NIBBLE_HI) | {4'h0, a[7:4]};
        acc_byte = 8'h00;
        acc_cnt = 3'd0;
        r.out_word = {24'h0, b};
        return 1'b1;
      end
      default: begin
        b = acc_byte | ((a & BIT_TOP) >> acc_cnt);
        if (acc_cnt == A1_LAST_BIT || last) begin
          acc_byte = 8'h00;
          acc_cnt = 3'd0;
          r.out_word = {24'h0, b};
          return 1'b1;
        end
        acc_byte = b;
        acc_cnt = acc_cnt + 3'd1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] a, input logic last);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    alpha <= a;
    row_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (convert_pixel(a, last, r)) expected_words.push_back(r);
    pixels_sent++;
  endtask

  // Waits until every result is out, then lets any pack-only beat settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== {{(DataW - 3){1'b0}}, fmt_model})
      report_mismatch("format readback", {{(DataW - 3){1'b0}}, fmt_model}, prdata);
    if (wr && addr == FORMAT_ADDR) begin
      fmt_model = fmt_e'(data[2:0]);
      acc_byte = 8'h00;
      acc_cnt = 3'd0;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_format(input fmt_e f);
    logic [DataW-1:0] data;
    data = $urandom;
    data[2:0] = f;
    apb_access(1'b1, FORMAT_ADDR, data);
  endtask

  function automatic logic [7:0] pick_alpha;
    case ($urandom_range(11))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_reset_state;
    apb_access(1'b0, FORMAT_ADDR, '0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h5A, 1'b1);
    drain();
  endtask

  task automatic test_plain_formats;
    set_format(FMT_AIRGB);
    send_pixel(8'hFF, 1'b1);
    drain();
    set_format(FMT_ARGB4444);
    send_pixel(8'h80, 1'b0);
    drain();
    set_format(FMT_ARGB2554);
    send_pixel(8'h01, 1'b1);
    drain();
    set_format(FMT_ARGB1555);
    send_pixel(8'hFE, 1'b0);
    drain();
    set_format(FMT_A8);
    send_pixel(8'h7F, 1'b1);
    drain();
    apb_access(1'b0, FORMAT_ADDR, '0);
  endtask

  task automatic test_pack_flush;
    set_format(FMT_A4);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h3C, 1'b0);
    // row end on a first nibble: low nibble comes out zero
    send_pixel(8'h9A, 1'b1);
    drain();
    set_format(FMT_A1);
    for (int i = 0; i < 8; i++) send_pixel(i[0] ? 8'h7F : 8'h80, 1'b0);
    // short A1 row: unused low bits zero
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hC0, 1'b1);
    drain();
  endtask

  task automatic test_register_writes;
    set_format(FMT_A4);
    send_pixel(8'hE7, 1'b0);
    drain();
    // unmapped register: pending nibble must survive
    apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_access(1'b0, FORMAT_ADDR, '0);
    send_pixel(8'h4B, 1'b0);
    send_pixel(8'h21, 1'b0);
    drain();
    // a format write drops the pending nibble
    set_format(FMT_A4);
    send_pixel(8'hD2, 1'b1);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(FMT_A8);
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_pixel(pick_alpha(), ($urandom_range(7) == 0));
    drain();
  endtask

  task automatic test_random_rows(input int s_pct, input int r_pct, input int n_items);
    int goal;
    int rows;
    int len;
    goal = pixels_sent + n_items;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (pixels_sent < goal) begin
      drain();
      set_format(fmt_e'($urandom_range(7)));
      if ($urandom_range(4) == 0) apb_access(1'b0, FORMAT_ADDR, '0);
      if ($urandom_range(9) == 0) apb_access(1'b1, UNMAPPED_ADDR, $urandom);
      rows = $urandom_range(2, 6);
      repeat (rows) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_pixel(pick_alpha(), (i == len - 1) || ($urandom_range(99) < 4));
      end
      // broken row: leave a partial pack for the next format write to drop
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 9)) send_pixel(pick_alpha(), 1'b0);
    end
    drain();
  endtask

  // receiver side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected beat", 32'h0, out_word);
      end else begin
        want = expected_words.pop_front();
        if (out_word !== want.out_word)
          report_mismatch("out_word", want.out_word, out_word);
        if (byte_count !== want.byte_count)
          report_mismatch("byte_count", 32'(want.byte_count), 32'(byte_count));
        if (row_done !== want.row_done)
          report_mismatch("row_done", 32'(want.row_done), 32'(row_done));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_plain_formats();
    test_pack_flush();
    test_register_writes();
    test_backpressure();
    test_random_rows(6, 48, 462);
    test_random_rows(48, 6, 462);
    test_random_rows(0, 0, 462);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("results missing", 32'h0, 32'(expected_words.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
